// ----- sv/imh_pkg.sv -----
// Shared constants, entry types and command/status codes of the indexed min-heap.
// Depends on nothing; imh_if and indexed_min_heap_top import it, imh_ram does not.
`default_nettype none

package imh_pkg;

    localparam int CAPACITY     = 1024;
    localparam int HANDLE_COUNT = 1024;
    localparam int SLOT_W       = $clog2(CAPACITY);
    localparam int HDL_W        = $clog2(HANDLE_COUNT);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int NH_W         = $clog2(HANDLE_COUNT + 1);
    localparam int VAL_W        = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELMIN = 2'd1;
    localparam logic [1:0] CMD_DELH   = 2'd2;
    localparam logic [1:0] CMD_MODIFY = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BADH  = 2'd3;

    typedef struct packed {
        logic [HDL_W-1:0]        hdl;
        logic signed [VAL_W-1:0] val;
    } t_hent;

    typedef struct packed {
        logic              live;
        logic [SLOT_W-1:0] slot;
    } t_sent;

endpackage

`default_nettype wire

// ----- sv/imh_if.sv -----
// Valid/ready channel interfaces for commands and results of the indexed min-heap.
// Depends on imh_pkg.
`default_nettype none

interface imh_cmd_if import imh_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic [HDL_W-1:0]        handle;
    logic signed [VAL_W-1:0] value;
    modport source (output valid, cmd, handle, value, input ready);
    modport sink   (input valid, cmd, handle, value, output ready);
endinterface

interface imh_res_if import imh_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] min_value;
    logic [CNT_W-1:0]        entries;
    logic [HDL_W-1:0]        assigned_handle;
    logic                    is_empty;
    logic [1:0]              status;
    modport source (output valid, min_value, entries, assigned_handle, is_empty, status,
                    input ready);
    modport sink   (input valid, min_value, entries, assigned_handle, is_empty, status,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/imh_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read.
// Stand-alone; used for the heap array and the handle map.
`default_nettype none

module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/indexed_min_heap_top.sv -----
// Top level of the indexed min-heap: command sequencer around the heap and handle RAMs.
// Depends on imh_pkg, imh_cmd_if, imh_res_if and imh_ram.
//
//   channel   direction  payload
//   i_cmd     in         cmd, handle, value
//   o_res     out        min_value, entries, assigned_handle, is_empty, status
//
// One command at a time. A sift moves in one direction only: each level walked down passes
// through S_DN, S_DNL and S_DNR, each level walked up through S_UP and S_UPC. A sift walks
// at most 9 levels down from the root.
// Both children are read in turn through the single read port of the heap RAM.
// Reset clears counts and control only; the RAMs need no clearing because handles at or
// above the issue counter are never looked up. A stalled result holds the sequencer.
`default_nettype none

module indexed_min_heap_top import imh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    imh_cmd_if.sink   i_cmd,
    imh_res_if.source o_res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DM0  = 4'd1;
    localparam logic [3:0] S_SL   = 4'd2;
    localparam logic [3:0] S_MODH = 4'd3;
    localparam logic [3:0] S_TAKE = 4'd4;
    localparam logic [3:0] S_DN   = 4'd5;
    localparam logic [3:0] S_DNL  = 4'd6;
    localparam logic [3:0] S_DNR  = 4'd7;
    localparam logic [3:0] S_UP   = 4'd8;
    localparam logic [3:0] S_UPC  = 4'd9;
    localparam logic [3:0] S_WR   = 4'd10;
    localparam logic [3:0] S_MIN  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    localparam int IX_W = SLOT_W + 2;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_cmd, n_cmd;
    logic [HDL_W-1:0]  r_h, n_h;
    logic [CNT_W-1:0]  r_size, n_size;
    logic [NH_W-1:0]   r_next, n_next;
    logic [SLOT_W-1:0] r_pos, n_pos;
    t_hent             r_cur, n_cur;
    t_hent             r_lent, n_lent;
    logic              r_moved, n_moved;
    logic [1:0]        r_status, n_status;
    logic [HDL_W-1:0]  r_asg, n_asg;
    logic [SLOT_W-1:0] r_hra, n_hra;

    logic                    r_ov;
    logic signed [VAL_W-1:0] r_omin;
    logic [CNT_W-1:0]        r_oent;
    logic [HDL_W-1:0]        r_oasg;
    logic                    r_oemp;
    logic [1:0]              r_ost;
    logic                    load_out;

    logic              h_we;
    logic [SLOT_W-1:0] h_wa;
    t_hent             h_wd, h_rd;
    logic              s_we;
    logic [HDL_W-1:0]  s_wa;
    t_sent             s_wd, s_rd;

    logic [IX_W-1:0]   lix, rix;
    logic [SLOT_W-1:0] par;
    logic [CNT_W-1:0]  last;
    logic              accept;

    imh_ram #(.WIDTH($bits(t_hent)), .DEPTH(CAPACITY)) u_heap (
        .i_clk  (i_clk),
        .i_we   (h_we),
        .i_waddr(h_wa),
        .i_wdata(h_wd),
        .i_raddr(n_hra),
        .o_rdata(h_rd)
    );

    imh_ram #(.WIDTH($bits(t_sent)), .DEPTH(HANDLE_COUNT)) u_slots (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_wa),
        .i_wdata(s_wd),
        .i_raddr(i_cmd.handle),
        .o_rdata(s_rd)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && (r_state == S_IDLE);
    assign lix  = {1'b0, r_pos, 1'b1};
    assign rix  = lix + IX_W'(1);
    assign par  = SLOT_W'((r_pos - SLOT_W'(1)) >> 1);
    assign last = r_size - CNT_W'(1);
    assign load_out = (r_state == S_FIN) && (!r_ov || o_res.ready);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_h      = r_h;
        n_size   = r_size;
        n_next   = r_next;
        n_pos    = r_pos;
        n_cur    = r_cur;
        n_lent   = r_lent;
        n_moved  = r_moved;
        n_status = r_status;
        n_asg    = r_asg;
        n_hra    = r_hra;
        h_we = 1'b0;
        h_wa = r_pos;
        h_wd = r_cur;
        s_we = 1'b0;
        s_wa = r_cur.hdl;
        s_wd = '{live: 1'b1, slot: r_pos};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_cmd.cmd;
                    n_h      = i_cmd.handle;
                    n_status = ST_OK;
                    n_asg    = '0;
                    n_moved  = 1'b0;
                    n_hra    = '0;
                    case (i_cmd.cmd)
                        CMD_INSERT: begin
                            if (r_size >= CNT_W'(CAPACITY) || r_next >= NH_W'(HANDLE_COUNT)) begin
                                n_status = ST_FULL;
                                n_state  = S_MIN;
                            end else begin
                                n_pos     = SLOT_W'(r_size);
                                n_cur.hdl = HDL_W'(r_next);
                                n_cur.val = i_cmd.value;
                                n_asg     = HDL_W'(r_next);
                                n_next    = r_next + NH_W'(1);
                                n_size    = r_size + CNT_W'(1);
                                n_state   = S_UP;
                            end
                        end
                        CMD_DELMIN: begin
                            if (r_size == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_MIN;
                            end else begin
                                n_pos   = '0;
                                n_state = S_DM0;
                            end
                        end
                        default: begin
                            // The new value of a modify is kept until its slot is known.
                            n_cur.val = i_cmd.value;
                            if (NH_W'(i_cmd.handle) >= r_next) begin
                                n_status = ST_BADH;
                                n_state  = S_MIN;
                            end else begin
                                n_state = S_SL;
                            end
                        end
                    endcase
                end
            end
            S_DM0: begin
                // Root handle dies; the last entry becomes the one to place.
                s_we    = 1'b1;
                s_wa    = h_rd.hdl;
                s_wd    = '{live: 1'b0, slot: '0};
                n_hra   = SLOT_W'(last);
                n_size  = last;
                n_state = S_TAKE;
            end
            S_SL: begin
                if (!s_rd.live) begin
                    n_status = ST_BADH;
                    n_state  = S_MIN;
                end else begin
                    n_pos = s_rd.slot;
                    if (r_cmd == CMD_MODIFY) begin
                        n_hra   = s_rd.slot;
                        n_state = S_MODH;
                    end else begin
                        s_we    = 1'b1;
                        s_wa    = r_h;
                        s_wd    = '{live: 1'b0, slot: '0};
                        n_hra   = SLOT_W'(last);
                        n_size  = last;
                        n_state = S_TAKE;
                    end
                end
            end
            S_MODH: begin
                n_cur.hdl = h_rd.hdl;
                n_state   = S_DN;
            end
            S_TAKE: begin
                n_cur = h_rd;
                if (CNT_W'(r_pos) >= r_size) begin
                    n_state = S_MIN;
                end else begin
                    n_state = S_DN;
                end
            end
            S_DN: begin
                if (lix >= IX_W'(r_size)) begin
                    n_state = r_moved ? S_WR : S_UP;
                end else begin
                    n_hra   = lix[SLOT_W-1:0];
                    n_state = S_DNL;
                end
            end
            S_DNL: begin
                n_lent  = h_rd;
                n_hra   = rix[SLOT_W-1:0];
                n_state = S_DNR;
            end
            S_DNR: begin
                if (rix < IX_W'(r_size) && $signed(h_rd.val) < $signed(r_lent.val)
                        && $signed(h_rd.val) < $signed(r_cur.val)) begin
                    h_we    = 1'b1;
                    h_wd    = h_rd;
                    s_we    = 1'b1;
                    s_wa    = h_rd.hdl;
                    n_pos   = rix[SLOT_W-1:0];
                    n_moved = 1'b1;
                    n_state = S_DN;
                end else if ($signed(r_lent.val) < $signed(r_cur.val)) begin
                    h_we    = 1'b1;
                    h_wd    = r_lent;
                    s_we    = 1'b1;
                    s_wa    = r_lent.hdl;
                    n_pos   = lix[SLOT_W-1:0];
                    n_moved = 1'b1;
                    n_state = S_DN;
                end else begin
                    n_state = r_moved ? S_WR : S_UP;
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    n_state = S_WR;
                end else begin
                    n_hra   = par;
                    n_state = S_UPC;
                end
            end
            S_UPC: begin
                if ($signed(h_rd.val) > $signed(r_cur.val)) begin
                    h_we    = 1'b1;
                    h_wd    = h_rd;
                    s_we    = 1'b1;
                    s_wa    = h_rd.hdl;
                    n_pos   = par;
                    n_state = S_UP;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                h_we    = 1'b1;
                s_we    = 1'b1;
                n_state = S_MIN;
            end
            S_MIN: begin
                n_hra   = '0;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= '0;
            r_next  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_next  <= n_next;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_h      <= n_h;
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_lent   <= n_lent;
        r_moved  <= n_moved;
        r_status <= n_status;
        r_asg    <= n_asg;
        r_hra    <= n_hra;
        if (load_out) begin
            r_omin <= (r_size == '0) ? '0 : h_rd.val;
            r_oent <= r_size;
            r_oasg <= r_asg;
            r_oemp <= (r_size == '0);
            r_ost  <= r_status;
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.min_value       = r_omin;
    assign o_res.entries         = r_oent;
    assign o_res.assigned_handle = r_oasg;
    assign o_res.is_empty        = r_oemp;
    assign o_res.status          = r_ost;

endmodule

`default_nettype wire
